@@ rtl/aes128_ctr_stream_cipher_defines.svh @@
// Assertion macros used by the AES-128 CTR stream cipher controller.
`ifndef AES128_CTR_STREAM_CIPHER_DEFINES_SVH
`define AES128_CTR_STREAM_CIPHER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define ACS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ACS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/acs_pkg.sv @@
// Package with the AES S-box table, a GF(2^8) helper function and shared types for the CTR cipher.
`default_nettype none
package acs_pkg;

  localparam int unsigned KeyW   = 128;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumRounds = 10;

  localparam logic [CfgIdxW-1:0] RegMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyHi  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyLo  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIvHi   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIvLo   = 3'd4;

  typedef struct packed {
    logic load_ctr;
    logic start;
    logic round;
    logic finish;
    logic load_out;
  } acs_cmd_t;

  typedef struct packed {
    logic last_round;
  } acs_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  // Doubling in GF(2^8) modulo the AES polynomial 0x11B.
  function automatic logic [7:0] gf_double(input logic [7:0] x);
    gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

endpackage
`default_nettype wire

@@ rtl/acs_ctrl.sv @@
// Controller state machine that sequences block encryptions and the byte stream.
`default_nettype none
`include "aes128_ctr_stream_cipher_defines.svh"
module acs_ctrl
  import acs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_write_i,
  input  wire logic     in_fire_i,
  input  wire logic     out_fire_i,
  input  wire acs_sts_t sts_i,
  output acs_cmd_t      cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output logic [3:0]    byte_sel_o
);

  typedef enum logic [1:0] {
    StIdle,
    StCrypt,
    StOut
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] pos_q, pos_d;
  logic       ovld_q, ovld_d;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    ovld_d  = ovld_q;
    cmd_o   = '0;
    if (out_fire_i) begin
      ovld_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_fire_i) begin
          if (pos_q[4]) begin
            cmd_o.start = 1'b1;
            state_d = StCrypt;
          end else begin
            state_d = StOut;
          end
        end
      end
      StCrypt: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) begin
          cmd_o.finish = 1'b1;
          pos_d = 5'd0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ovld_q || out_fire_i) begin
          cmd_o.load_out = 1'b1;
          ovld_d = 1'b1;
          pos_d = pos_q + 5'd1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (cfg_write_i) begin
      cmd_o.load_ctr = 1'b1;
      pos_d = 5'd16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= 5'd16;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      ovld_q  <= ovld_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovld_q;
  assign byte_sel_o  = pos_q[3:0];

  `ACS_ASSERT_IMP(a_pos_range, clk_i, rst_ni, 1'b1, pos_q <= 5'd16, "byte position too large")
  `ACS_ASSERT_IMP(a_start_empty, clk_i, rst_ni, cmd_o.start, pos_q == 5'd16,
                  "block started with keystream left")
  `ACS_ASSERT_NEXT(a_finish_out, clk_i, rst_ni, cmd_o.finish && !cfg_write_i,
                   state_q == StOut && pos_q == 5'd0, "finish did not reset position")

endmodule
`default_nettype wire

@@ rtl/acs_datapath.sv @@
// Datapath with the counter, an iterative AES-128 round and on-the-fly key expansion.
`default_nettype none
module acs_datapath
  import acs_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire acs_cmd_t        cmd_i,
  input  wire logic            mode_i,
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic [KeyW-1:0] iv_i,
  input  wire logic [7:0]      data_i,
  input  wire logic            in_fire_i,
  input  wire logic [3:0]      byte_sel_i,
  output acs_sts_t             sts_o,
  output logic [7:0]           out_byte_o
);

  logic [KeyW-1:0] ctr_q, ks_q, st_q, rk_q;
  logic [KeyW-1:0] st_d, rk_d, ctr_init;
  logic [3:0]      rnd_q;
  logic [7:0]      rcon_q, data_q, out_q;
  logic [7:0]      sb [16];
  logic [7:0]      sr [16];
  logic [7:0]      mc [16];
  logic [7:0]      rb [16];
  logic [7:0]      nk [16];
  logic [7:0]      t [4];
  logic [7:0]      ks_byte;

  assign ctr_init = mode_i ? {8'h01, iv_i[127:24], 16'h0001} : iv_i;

  // Byte i of a 128-bit block sits in bits 127-8i down to 120-8i.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rb[i] = rk_q[127-8*i -: 8];
      sb[i] = SBOX[st_q[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[i+4*c] = sb[i+4*((c+i)%4)];
      end
    end
    for (int c = 0; c < 16; c += 4) begin
      mc[c]   = sr[c]   ^ (sr[c]^sr[c+1]^sr[c+2]^sr[c+3]) ^ gf_double(sr[c]^sr[c+1]);
      mc[c+1] = sr[c+1] ^ (sr[c]^sr[c+1]^sr[c+2]^sr[c+3]) ^ gf_double(sr[c+1]^sr[c+2]);
      mc[c+2] = sr[c+2] ^ (sr[c]^sr[c+1]^sr[c+2]^sr[c+3]) ^ gf_double(sr[c+2]^sr[c+3]);
      mc[c+3] = sr[c+3] ^ (sr[c]^sr[c+1]^sr[c+2]^sr[c+3]) ^ gf_double(sr[c+3]^sr[c]);
    end
    for (int i = 0; i < 4; i++) begin
      t[i] = SBOX[rb[12 + ((i+1)%4)]];
    end
    t[0] = t[0] ^ rcon_q;
    for (int i = 0; i < 4; i++) begin
      nk[i] = rb[i] ^ t[i];
    end
    for (int i = 4; i < 16; i++) begin
      nk[i] = rb[i] ^ nk[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      rk_d[127-8*i -: 8] = nk[i];
      st_d[127-8*i -: 8] = ((rnd_q == 4'd9) ? sr[i] : mc[i]) ^ nk[i];
    end
  end

  assign sts_o.last_round = (rnd_q == 4'(NumRounds - 1));
  assign ks_byte = ks_q[127 - 8*byte_sel_i -: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q  <= '0;
      rnd_q  <= '0;
      rcon_q <= 8'h01;
    end else begin
      if (cmd_i.start) begin
        rnd_q  <= '0;
        rcon_q <= 8'h01;
      end else if (cmd_i.round) begin
        rnd_q  <= rnd_q + 4'd1;
        rcon_q <= gf_double(rcon_q);
      end
      if (cmd_i.load_ctr) begin
        ctr_q <= ctr_init;
      end else if (cmd_i.finish) begin
        ctr_q <= ctr_q + 128'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      data_q <= data_i;
    end
    if (cmd_i.start) begin
      st_q <= ctr_q ^ key_i;
      rk_q <= key_i;
    end else if (cmd_i.round) begin
      st_q <= st_d;
      rk_q <= rk_d;
    end
    if (cmd_i.finish) begin
      ks_q <= st_d;
    end
    if (cmd_i.load_out) begin
      out_q <= data_q ^ ks_byte;
    end
  end

  assign out_byte_o = out_q;

endmodule
`default_nettype wire

@@ rtl/aes128_ctr_stream_cipher.sv @@
// Top level of the AES-128 CTR / CCM* byte stream cipher.
`default_nettype none
// Each byte is XORed with the next AES-128 keystream byte. Bytes are handled
// one at a time by the controller's sequence. A byte that finds the keystream
// used up first encrypts the counter block, one round per cycle with
// on-the-fly key expansion, then has its result registered in the output
// state; only then is the next request taken. Any other byte goes straight to
// the output state, where its result is registered, and the next request is
// taken after that. A result that is not taken holds back the next result.
// A configuration write to a defined register (index 0 to 4) reloads the
// counter and empties the keystream; write configuration only while idle.
module aes128_ctr_stream_cipher
  import acs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // data_byte
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [7:0]              m_axis_tdata    // out_byte
);

  logic          mode_q, mode_d;
  logic [63:0]   key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic [63:0]   key_hi_d, key_lo_d, iv_hi_d, iv_lo_d;
  logic          cfg_fire, cfg_hit, in_fire, out_fire;
  logic [3:0]    byte_sel;
  acs_cmd_t      cmd;
  acs_sts_t      sts;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign cfg_hit     = cfg_fire && (cfg_index_i <= RegIvLo);
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign out_fire    = m_axis_tvalid && m_axis_tready;

  always_comb begin
    mode_d   = mode_q;
    key_hi_d = key_hi_q;
    key_lo_d = key_lo_q;
    iv_hi_d  = iv_hi_q;
    iv_lo_d  = iv_lo_q;
    if (cfg_fire) begin
      unique case (cfg_index_i)
        RegMode:  mode_d   = cfg_data_i[0];
        RegKeyHi: key_hi_d = cfg_data_i;
        RegKeyLo: key_lo_d = cfg_data_i;
        RegIvHi:  iv_hi_d  = cfg_data_i;
        RegIvLo:  iv_lo_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      key_hi_q <= key_hi_d;
      key_lo_q <= key_lo_d;
      iv_hi_q  <= iv_hi_d;
      iv_lo_q  <= iv_lo_d;
    end
  end

  acs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_hit),
    .in_fire_i   (in_fire),
    .out_fire_i  (out_fire),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .byte_sel_o  (byte_sel)
  );

  // The counter reloads at the write edge, from the values being written.
  acs_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .mode_i     (mode_d),
    .key_i      ({key_hi_q, key_lo_q}),
    .iv_i       ({iv_hi_d, iv_lo_d}),
    .data_i     (s_axis_tdata),
    .in_fire_i  (in_fire),
    .byte_sel_i (byte_sel),
    .sts_o      (sts),
    .out_byte_o (m_axis_tdata)
  );

endmodule
`default_nettype wire
